// File: src/hufd_pkg.sv
// Shared types, sizes and codes for the preorder Huffman tree decoder.
// No dependencies; every other file of the block imports this package.
package hufd_pkg;

    // Tree size limits
    localparam int MAX_SYMBOLS = 256;
    localparam int SYMBOL_BITS = 8;

    localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int NUSED_W    = $clog2(NODE_COUNT + 1);
    localparam int DEPTH_W    = $clog2(MAX_SYMBOLS + 1);
    localparam int STACK_AW   = $clog2(MAX_SYMBOLS);
    localparam int SYM_W      = (SYMBOL_BITS < 8) ? SYMBOL_BITS : 8;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_NODE  = 2'd1;
    localparam logic [1:0] OP_BIT   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_LOADED = 2'd1;
    localparam logic [1:0] KIND_FAULT  = 2'd2;

    typedef logic [NODE_W-1:0] node_idx_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       tree_bit;
        logic [7:0] leaf_symbol;
        logic       message_bit;
    } item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] symbol;
    } result_t;

    // One branch of a node: the child it leads to, and what that child is.
    typedef struct packed {
        node_idx_t        idx;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } child_entry_t;

    typedef struct packed {
        logic         en;
        node_idx_t    addr;
        child_entry_t entry;
    } child_wr_t;

    typedef struct packed {
        logic                en;
        logic [STACK_AW-1:0] addr;
        node_idx_t           idx;
    } stack_wr_t;

endpackage

// File: src/hufd_child_mem.sv
// Branch table for one side (zero or one) of every node of the tree.
// Depends on hufd_pkg. Registered read with write-first bypass.
module hufd_child_mem
    import hufd_pkg::*;
(
    input  logic         clk,
    input  child_wr_t    wr,
    input  node_idx_t    rd_addr,
    output child_entry_t rd_entry
);

    child_entry_t mem [0:NODE_COUNT-1];
    child_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
    end

    // A write to the address being read this cycle is seen at once.
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_entry_reg <= wr.entry;
        end
        else
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// File: src/hufd_stack_mem.sv
// Stack of open parent nodes used while a tree is loaded.
// Depends on hufd_pkg. Registered read with write-first bypass.
module hufd_stack_mem
    import hufd_pkg::*;
(
    input  logic                clk,
    input  stack_wr_t           wr,
    input  logic [STACK_AW-1:0] rd_addr,
    output node_idx_t           rd_idx
);

    node_idx_t mem [0:MAX_SYMBOLS-1];
    node_idx_t rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_idx_reg <= wr.idx;
        end
        else
        begin
            rd_idx_reg <= mem[rd_addr];
        end
    end

    assign rd_idx = rd_idx_reg;

endmodule

// File: src/huffman_tree_decoder.sv
// Top level of the preorder Huffman tree decoder: control, state and handshakes.
// Depends on hufd_pkg, hufd_child_mem and hufd_stack_mem.
//
// Usage. Items arrive on the item channel (item_valid, item_stall, item) and
// results leave on the result channel (result_valid, result_stall, result).
// An item is taken at a clock edge with valid high and stall low. A clear item
// starts a new tree; node items then load the tree in preorder, and the item
// that completes it returns a "tree loaded" result. Message bit items each
// step one branch down the tree; reaching a leaf returns its symbol and goes
// back to the root. Misuse (a bit with no tree, a full table or stack, a tree
// that is a single leaf, a node item after completion) returns a fault.
//
// Timing. An accepted item is held in an input register and processed once the
// result slot is free or being emptied; its result, if it has one, is offered
// from the result register. One item per cycle is sustained while the receiver
// does not stall: the branch tables are read at the node that will be current
// for the next item, so each step needs a single registered memory read.
//
// Reset clears the tree (no tree loaded, decoder at the root) and empties both
// registers. The tables need no clearing pass. While the receiver stalls, the
// result is held and one further item may still be taken into the input
// register; item_stall rises only when that register is also occupied.
module huffman_tree_decoder
    import hufd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Input and result registers
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;

    // Decoder state
    logic [DEPTH_W-1:0] stack_depth_reg, stack_depth_next;
    logic               top_zs_reg, top_zs_next;
    logic [NUSED_W-1:0] nodes_used_reg, nodes_used_next;
    logic               tree_ready_reg, tree_ready_next;
    node_idx_t          current_node_reg, current_node_next;

    logic    fire;
    logic    emit;
    result_t emit_res;

    child_wr_t    zero_wr, one_wr;
    stack_wr_t    stack_wr;
    child_entry_t zero_rd, one_rd, branch;
    node_idx_t    child_rd_addr;
    node_idx_t    stack_top;
    logic [STACK_AW-1:0] stack_rd_addr;
    logic [DEPTH_W-1:0]  depth_eff;

    // Node item working values
    logic               internal;
    logic               has_parent;
    logic               node_fault;
    logic [DEPTH_W-1:0] depth_after;
    logic [DEPTH_W-1:0] depth_pop;
    child_entry_t       new_entry;

    // The item in the input register is processed once the result slot is
    // free or being emptied this cycle.
    assign fire       = in_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !fire;

    assign internal    = in_item_reg.tree_bit;
    assign has_parent  = (nodes_used_reg != '0) && (stack_depth_reg != '0);
    assign depth_after = stack_depth_reg - DEPTH_W'(has_parent && top_zs_reg);
    assign node_fault  = tree_ready_reg
                      || (nodes_used_reg >= NUSED_W'(NODE_COUNT))
                      || ((nodes_used_reg == '0) && !internal)
                      || (internal && (depth_after >= DEPTH_W'(MAX_SYMBOLS)));
    assign depth_pop   = depth_after;

    always_comb
    begin
        new_entry.idx  = node_idx_t'(nodes_used_reg);
        new_entry.leaf = !internal;
        new_entry.sym  = internal ? '0 : in_item_reg.leaf_symbol[SYM_W-1:0];
    end

    assign branch = in_item_reg.message_bit ? one_rd : zero_rd;

    always_comb
    begin
        stack_depth_next  = stack_depth_reg;
        top_zs_next       = top_zs_reg;
        nodes_used_next   = nodes_used_reg;
        tree_ready_next   = tree_ready_reg;
        current_node_next = current_node_reg;
        emit              = 1'b0;
        emit_res          = '0;
        zero_wr           = '0;
        one_wr            = '0;
        stack_wr          = '0;

        if (fire)
        begin
            unique case (in_item_reg.operation)
                OP_CLEAR:
                begin
                    stack_depth_next  = '0;
                    nodes_used_next   = '0;
                    tree_ready_next   = 1'b0;
                    current_node_next = '0;
                end
                OP_NODE:
                begin
                    if (node_fault)
                    begin
                        emit                 = 1'b1;
                        emit_res.result_kind = KIND_FAULT;
                    end
                    else
                    begin
                        // Attach to the open parent: zero branch first, then
                        // the one branch, which closes the parent.
                        if (has_parent)
                        begin
                            if (!top_zs_reg)
                            begin
                                zero_wr.en    = 1'b1;
                                zero_wr.addr  = stack_top;
                                zero_wr.entry = new_entry;
                            end
                            else
                            begin
                                one_wr.en    = 1'b1;
                                one_wr.addr  = stack_top;
                                one_wr.entry = new_entry;
                            end
                            // Every parent left below the top already has its
                            // zero branch.
                            top_zs_next = 1'b1;
                        end
                        stack_depth_next = depth_pop;
                        nodes_used_next  = nodes_used_reg + NUSED_W'(1);

                        if (internal)
                        begin
                            stack_wr.en      = 1'b1;
                            stack_wr.addr    = depth_pop[STACK_AW-1:0];
                            stack_wr.idx     = node_idx_t'(nodes_used_reg);
                            stack_depth_next = depth_pop + DEPTH_W'(1);
                            top_zs_next      = 1'b0;
                        end
                        else if (depth_pop == '0)
                        begin
                            tree_ready_next      = 1'b1;
                            current_node_next    = '0;
                            emit                 = 1'b1;
                            emit_res.result_kind = KIND_LOADED;
                        end
                    end
                end
                OP_BIT:
                begin
                    if (!tree_ready_reg)
                    begin
                        emit                 = 1'b1;
                        emit_res.result_kind = KIND_FAULT;
                    end
                    else if (branch.leaf)
                    begin
                        current_node_next    = '0;
                        emit                 = 1'b1;
                        emit_res.result_kind = KIND_SYMBOL;
                        emit_res.symbol      = 8'(branch.sym);
                    end
                    else
                    begin
                        current_node_next = branch.idx;
                    end
                end
                default:
                begin
                    // Unused code: no effect.
                end
            endcase
        end
    end

    // Read at the state the next item will see.
    assign child_rd_addr = current_node_next;
    assign depth_eff     = stack_depth_next;
    assign stack_rd_addr = STACK_AW'(depth_eff - DEPTH_W'(1));

    hufd_child_mem u_zero_mem
    (
        .clk      (clk),
        .wr       (zero_wr),
        .rd_addr  (child_rd_addr),
        .rd_entry (zero_rd)
    );

    hufd_child_mem u_one_mem
    (
        .clk      (clk),
        .wr       (one_wr),
        .rd_addr  (child_rd_addr),
        .rd_entry (one_rd)
    );

    hufd_stack_mem u_stack_mem
    (
        .clk     (clk),
        .wr      (stack_wr),
        .rd_addr (stack_rd_addr),
        .rd_idx  (stack_top)
    );

    always_comb
    begin
        if (fire && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            stack_depth_reg  <= '0;
            top_zs_reg       <= 1'b0;
            nodes_used_reg   <= '0;
            tree_ready_reg   <= 1'b0;
            current_node_reg <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            res_valid_reg    <= res_valid_next;
            stack_depth_reg  <= stack_depth_next;
            top_zs_reg       <= top_zs_next;
            nodes_used_reg   <= nodes_used_next;
            tree_ready_reg   <= tree_ready_next;
            current_node_reg <= current_node_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
        if (fire && emit)
        begin
            res_reg <= emit_res;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// File: src/hufd_checker.sv
// Port-level checks for huffman_tree_decoder, attached by the bind below.
// Depends on hufd_pkg and on the port list of huffman_tree_decoder.
module hufd_checker
    import hufd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // Only the three defined result kinds are ever offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.result_kind == KIND_SYMBOL)
                       || (result.result_kind == KIND_LOADED)
                       || (result.result_kind == KIND_FAULT)))
        else $error("undefined result kind offered");

    // Loaded and fault results carry a zero symbol.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.result_kind != KIND_SYMBOL)) |-> (result.symbol == 8'd0))
        else $error("non-symbol result with a non-zero symbol");

    // With the result slot empty, the input side can always take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stalled while no result is pending");

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result dropped or changed");

endmodule

bind huffman_tree_decoder hufd_checker u_hufd_checker (.*);
